FILE: hdl/gitc_pkg.sv
`timescale 1ns / 1ps

package gitc_pkg;

    // Coordinate count of the grid (2 or 3) and coordinate width limit
    localparam int NUM_COORDS  = 3;
    localparam int COORD_BITS  = 16;

    localparam int ACC_W       = 32;            // parsed number width
    localparam int EXT_W       = 17;            // extent register width
    localparam int OUT_W       = 16;            // coordinate output width
    localparam int PROD_W      = 2 * EXT_W;     // extent_i * extent_j
    localparam int NSEEN_W     = 3;
    localparam int DIV_CNT_W   = $clog2(ACC_W + 1);
    localparam bit HAS_K       = (NUM_COORDS >= 3);

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // coordinate must stay below min(2**COORD_BITS, 2**OUT_W)
    localparam logic [ACC_W:0] COORD_LIMIT = (COORD_BITS < OUT_W) ?
        ((ACC_W + 1)'(1) << COORD_BITS) : ((ACC_W + 1)'(1) << OUT_W);

    // register map, index = paddr[3:2]
    localparam logic [1:0] REG_EXTENT_I = 2'd0;
    localparam logic [1:0] REG_EXTENT_J = 2'd1;
    localparam logic [1:0] REG_EXTENT_K = 2'd2;
    localparam logic [1:0] REG_THREE_D  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV1_GO,
        ST_DIV1_RUN,
        ST_DIV2_GO,
        ST_DIV2_RUN,
        ST_CHECK
    } state_t;

    typedef struct packed {
        logic [EXT_W-1:0] extent_i;
        logic [EXT_W-1:0] extent_j;
        logic [EXT_W-1:0] extent_k;
        logic             three_d;
    } cfg_t;

    typedef struct packed {
        logic parse;        // accepted character beat
        logic calc;         // latch flags, product, direct coordinates
        logic div_go;       // start divider
        logic div_second;   // second division (remainder / extent_i)
        logic cap_first;    // capture first division result
        logic cap_second;   // capture second division result
        logic load_out;     // load output register, clear parser
    } cmd_t;

    typedef struct packed {
        logic linear;       // single number, split by extents
        logic is3;
        logic div_busy;
        logic out_free;
    } status_t;

endpackage

FILE: hdl/gitc_ctrl.sv
`timescale 1ns / 1ps

module gitc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    input  gitc_pkg::status_t sts,
    output gitc_pkg::cmd_t    cmd
);
    import gitc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.parse = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.calc   = 1'b1;
                state_next = ST_DIV1_GO;
            end
            ST_DIV1_GO: begin
                if (sts.linear) begin
                    cmd.div_go = 1'b1;
                    state_next = ST_DIV1_RUN;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_DIV1_RUN: begin
                if (!sts.div_busy) begin
                    cmd.cap_first = 1'b1;
                    state_next    = sts.is3 ? ST_DIV2_GO : ST_CHECK;
                end
            end
            ST_DIV2_GO: begin
                cmd.div_go     = 1'b1;
                cmd.div_second = 1'b1;
                state_next     = ST_DIV2_RUN;
            end
            ST_DIV2_RUN: begin
                if (!sts.div_busy) begin
                    cmd.cap_second = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/gitc_dp.sv
`timescale 1ns / 1ps

module gitc_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gitc_pkg::cfg_t                cfg,
    input  gitc_pkg::cmd_t                cmd,
    output gitc_pkg::status_t             sts,
    input  logic [7:0]                    char_code,
    input  logic                          last_char,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic                          index_valid,
    output logic [gitc_pkg::OUT_W-1:0]    coord_i,
    output logic [gitc_pkg::OUT_W-1:0]    coord_j,
    output logic [gitc_pkg::OUT_W-1:0]    coord_k
);
    import gitc_pkg::*;

    // parser state
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               inside_reg, inside_next;
    logic [NSEEN_W-1:0] nseen_reg, nseen_next;
    logic               ovf_reg, ovf_next;
    logic [ACC_W-1:0]   vals_reg [3];

    // resolve state
    logic [PROD_W-1:0]  mij_reg;
    logic               linear_reg, okb_reg;
    logic [ACC_W-1:0]   ci_reg, cj_reg, ck_reg;

    // divider
    logic [ACC_W-1:0]     quot_reg;
    logic [PROD_W-1:0]    rem_reg, dvs_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;

    // output register
    logic               tvalid_reg;
    logic               ivalid_reg;
    logic [OUT_W-1:0]   oi_reg, oj_reg, ok_reg;

    logic               is3;
    logic [NSEEN_W-1:0] need;
    logic               is_digit;
    logic [ACC_W+3:0]   acc_x10;
    logic               sat;
    logic [ACC_W-1:0]   acc_dig;
    logic               do_close, close_in, store_num;
    logic [ACC_W-1:0]   close_acc;
    logic               ok0;
    logic [PROD_W:0]    rem_sh;
    logic [PROD_W+1:0]  sub;
    logic               in_range;

    assign is3  = cfg.three_d && HAS_K;
    assign need = is3 ? NSEEN_W'(3) : NSEEN_W'(2);

    // character parsing
    always_comb begin
        is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
        acc_x10   = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                  + (ACC_W + 4)'(char_code - CHAR_ZERO);
        sat       = |acc_x10[ACC_W+3:ACC_W];
        acc_dig   = sat ? {ACC_W{1'b1}} : acc_x10[ACC_W-1:0];
        do_close  = !is_digit || last_char;
        close_acc = is_digit ? acc_dig : acc_reg;
        close_in  = is_digit || inside_reg;
        store_num = cmd.parse && do_close && close_in && (nseen_reg < need);

        acc_next    = acc_reg;
        inside_next = inside_reg;
        nseen_next  = nseen_reg;
        ovf_next    = ovf_reg;
        if (cmd.parse) begin
            acc_next    = do_close ? '0 : acc_dig;
            inside_next = !do_close;
            if (is_digit && sat && (nseen_reg < need)) begin
                ovf_next = 1'b1;
            end
            if (store_num) begin
                nseen_next = nseen_reg + NSEEN_W'(1);
            end
        end
        if (cmd.load_out) begin
            acc_next    = '0;
            inside_next = 1'b0;
            nseen_next  = '0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            inside_reg <= 1'b0;
            nseen_reg  <= '0;
            ovf_reg    <= 1'b0;
        end else begin
            acc_reg    <= acc_next;
            inside_reg <= inside_next;
            nseen_reg  <= nseen_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_num) begin
            vals_reg[nseen_reg[1:0]] <= close_acc;
        end
    end

    // resolve: flags, product, coordinates
    assign ok0 = !ovf_reg && (cfg.extent_i != '0) && (cfg.extent_j != '0)
               && (!is3 || (cfg.extent_k != '0));

    always_comb begin
        rem_sh = {rem_reg, quot_reg[ACC_W-1]};
        sub    = {1'b0, rem_sh} - {2'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            mij_reg    <= PROD_W'(cfg.extent_i) * PROD_W'(cfg.extent_j);
            linear_reg <= ok0 && (nseen_reg == NSEEN_W'(1));
            okb_reg    <= ok0 && ((nseen_reg == NSEEN_W'(1)) || (nseen_reg == need));
            ci_reg     <= vals_reg[0];
            cj_reg     <= vals_reg[1];
            ck_reg     <= is3 ? vals_reg[2] : '0;
        end
        if (cmd.cap_first) begin
            if (is3) begin
                ck_reg <= quot_reg;
            end else begin
                ci_reg <= rem_reg[ACC_W-1:0];
                cj_reg <= quot_reg;
                ck_reg <= '0;
            end
        end
        if (cmd.cap_second) begin
            ci_reg <= rem_reg[ACC_W-1:0];
            cj_reg <= quot_reg;
        end
    end

    // restoring divider, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_go) begin
            dcnt_reg <= DIV_CNT_W'(ACC_W);
        end else if (dcnt_reg != '0) begin
            dcnt_reg <= dcnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_go) begin
            rem_reg <= '0;
            if (cmd.div_second) begin
                quot_reg <= rem_reg[ACC_W-1:0];
                dvs_reg  <= PROD_W'(cfg.extent_i);
            end else begin
                quot_reg <= vals_reg[0];
                dvs_reg  <= is3 ? mij_reg : PROD_W'(cfg.extent_i);
            end
        end else if (dcnt_reg != '0) begin
            if (!sub[PROD_W+1]) begin
                rem_reg  <= sub[PROD_W-1:0];
                quot_reg <= {quot_reg[ACC_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[PROD_W-1:0];
                quot_reg <= {quot_reg[ACC_W-2:0], 1'b0};
            end
        end
    end

    // range check and output register
    always_comb begin
        in_range = okb_reg
            && (ci_reg < ACC_W'(cfg.extent_i)) && (cj_reg < ACC_W'(cfg.extent_j))
            && ({1'b0, ci_reg} < COORD_LIMIT) && ({1'b0, cj_reg} < COORD_LIMIT)
            && (!is3 || ((ck_reg < ACC_W'(cfg.extent_k))
                         && ({1'b0, ck_reg} < COORD_LIMIT)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            ivalid_reg <= in_range;
            oi_reg     <= in_range ? ci_reg[OUT_W-1:0] : '0;
            oj_reg     <= in_range ? cj_reg[OUT_W-1:0] : '0;
            ok_reg     <= in_range ? ck_reg[OUT_W-1:0] : '0;
        end
    end

    assign sts.linear   = linear_reg;
    assign sts.is3      = is3;
    assign sts.div_busy = (dcnt_reg != '0);
    assign sts.out_free = !tvalid_reg || m_tready;

    assign m_tvalid    = tvalid_reg;
    assign index_valid = ivalid_reg;
    assign coord_i     = oi_reg;
    assign coord_j     = oj_reg;
    assign coord_k     = ok_reg;

endmodule

FILE: hdl/grid_index_text_to_coords_unit.sv
`timescale 1ns / 1ps

// Grid index text to coordinates.
// Input stream: one character per beat, s_tdata[7:0] = char_code, s_tlast marks
// the final character of an index string. Digit runs form unsigned decimal
// numbers; any other byte separates them.
// Output stream: one beat per string, m_tdata = {coord_k, coord_j, coord_i},
// m_tuser = index_valid. Invalid results carry all-zero coordinates.
// Config (APB, 32-bit data): 0x0 extent_i, 0x4 extent_j, 0x8 extent_k, 0xC three_d.
// After the final beat the parsed numbers are latched; a coordinate list then
// goes to the range check, while a linear index is first split by the shared
// 32-step restoring divider (one quotient bit per cycle, two divisions in 3D,
// one in 2D). Throughput: one character per cycle while s_tready is high;
// after the final beat s_tready stays low while the string is resolved.
// s_tready drops from the final beat until the result is loaded into the
// output register; characters of the next string are then taken while the
// result still waits for m_tready. A stalled receiver holds the result and
// only blocks the resolve of the following string.
// Reset (aresetn low, synchronous) clears parser state and the output valid,
// and sets extents to 1 and three_d to 1.

module grid_index_text_to_coords_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_code
    input  logic        s_tlast,    // last_char
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [15:0] coord_i, [31:16] coord_j, [47:32] coord_k
    output logic        m_tuser,    // index_valid
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gitc_pkg::*;

    logic [EXT_W-1:0] ext_i_reg, ext_j_reg, ext_k_reg;
    logic             three_d_reg;
    logic             cfg_wr;
    cfg_t             cfg;
    cmd_t             cmd;
    status_t          sts;
    logic [OUT_W-1:0] coord_i, coord_j, coord_k;

    // register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_i_reg   <= EXT_W'(1);
            ext_j_reg   <= EXT_W'(1);
            ext_k_reg   <= EXT_W'(1);
            three_d_reg <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_EXTENT_I: ext_i_reg   <= pwdata[EXT_W-1:0];
                REG_EXTENT_J: ext_j_reg   <= pwdata[EXT_W-1:0];
                REG_EXTENT_K: ext_k_reg   <= pwdata[EXT_W-1:0];
                REG_THREE_D:  three_d_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_EXTENT_I: prdata = 32'(ext_i_reg);
            REG_EXTENT_J: prdata = 32'(ext_j_reg);
            REG_EXTENT_K: prdata = 32'(ext_k_reg);
            REG_THREE_D:  prdata = 32'(three_d_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.extent_i = ext_i_reg;
    assign cfg.extent_j = ext_j_reg;
    assign cfg.extent_k = ext_k_reg;
    assign cfg.three_d  = three_d_reg;

    gitc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gitc_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .cmd         (cmd),
        .sts         (sts),
        .char_code   (s_tdata),
        .last_char   (s_tlast),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .index_valid (m_tuser),
        .coord_i     (coord_i),
        .coord_j     (coord_j),
        .coord_k     (coord_k)
    );

    assign m_tdata = {coord_k, coord_j, coord_i};

    // invalid result carries zero coordinates
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("invalid result with non-zero coordinates");

    // final beat closes the input until the result is resolved
    a_last_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input accepted straight after final beat");

    // a new result is only loaded while the input is held off
    a_load_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result loaded while input open");

    // valid coordinates lie inside the i and j extents
    a_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (EXT_W'(m_tdata[15:0]) < ext_i_reg)
                              && (EXT_W'(m_tdata[31:16]) < ext_j_reg))
        else $error("valid result outside grid extents");

endmodule
